/* rtl/core/vrt_pkg.sv */
// Shared constants, types and command codes of the voxel ray traversal unit.
`default_nettype none
package vrt_pkg;

   localparam int GRID_X    = 64;
   localparam int GRID_Y    = 64;
   localparam int GRID_Z    = 64;
   localparam int MAX_STEPS = 512;

   localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   // start cell spans -128..127, the walk moves at most MAX_STEPS cells from it
   localparam int CELL_W = $clog2(MAX_STEPS + 256) + 2;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int CNT_W  = ADDR_W;
   localparam int ITER   = 32;           // result bits of the root and of each quotient
   localparam int JOBS   = 6;            // three crossing times, three first boundaries
   localparam int TIME_W = 32;

   localparam logic [TIME_W-1:0] T_INF    = '1;
   localparam logic [31:0]       SUM_MIN  = 32'd2;
   localparam logic              KIND_WRITE = 1'b0;
   localparam logic              KIND_RAY   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUMSQ,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_STORE,
      ST_WALK_CHK,
      ST_WALK_READ,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR_WR,
      OP_BLOCK_WR,
      OP_RAY_LOAD,
      OP_SUMSQ,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_STORE,
      OP_WALK_READ,
      OP_WALK_EVAL,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               req_ready;
      logic [2:0]         idx;
      logic [ADDR_W-1:0]  addr;
   } cmd_type;

   typedef struct packed {
      logic near_zero;
      logic walk_go;
      logic cell_hit;
      logic rsp_free;
   } stat_type;

endpackage
`default_nettype wire

/* rtl/core/vrt_req_if.sv */
// Request channel: block writes and ray casts.
`default_nettype none
interface vrt_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [7:0]  block_x;
   logic signed [7:0]  block_y;
   logic signed [7:0]  block_z;
   logic [7:0]         block_type;
   logic signed [15:0] origin_x;
   logic signed [15:0] origin_y;
   logic signed [15:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [15:0]        max_distance;

   modport source (output valid, kind, block_x, block_y, block_z, block_type,
                   origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance,
                   input ready);
   modport sink (input valid, kind, block_x, block_y, block_z, block_type,
                 origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance,
                 output ready);
endinterface
`default_nettype wire

/* rtl/core/vrt_rsp_if.sv */
// Response channel: ray cast results.
`default_nettype none
interface vrt_rsp_if;
   logic              valid;
   logic              ready;
   logic              hit;
   logic signed [7:0] hit_x;
   logic signed [7:0] hit_y;
   logic signed [7:0] hit_z;
   logic signed [1:0] normal_x;
   logic signed [1:0] normal_y;
   logic signed [1:0] normal_z;

   modport source (output valid, hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                   input ready);
   modport sink (input valid, hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                 output ready);
endinterface
`default_nettype wire

/* rtl/core/vrt_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module vrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/vrt_ctrl.sv */
// Sequencer of the voxel ray traversal unit.
`default_nettype none
module vrt_ctrl import vrt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_kind,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2:0]        job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         job_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         job_ff   <= job_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      job_in        = job_ff;
      cmd.op        = OP_NONE;
      cmd.req_ready = 1'b0;
      cmd.idx       = job_ff;
      cmd.addr      = cnt_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR_WR;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_WRITE) begin
                  cmd.op = OP_BLOCK_WR;
               end else begin
                  cmd.op   = OP_RAY_LOAD;
                  state_in = ST_SUMSQ;
                  job_in   = '0;
               end
            end
         end
         ST_SUMSQ: begin
            cmd.op = OP_SUMSQ;
            if (job_ff == 3'd2) begin
               state_in = ST_SQRT_INIT;
               job_in   = '0;
            end else begin
               job_in = job_ff + 1'b1;
            end
         end
         ST_SQRT_INIT: begin
            if (stat.near_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_SQRT_INIT;
               state_in = ST_SQRT;
               cnt_in   = '0;
            end
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == CNT_W'(ITER - 1)) begin
               state_in = ST_DIV_INIT;
               cnt_in   = '0;
               job_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == CNT_W'(ITER - 1)) begin
               state_in = ST_DIV_STORE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_STORE: begin
            cmd.op = OP_DIV_STORE;
            if (job_ff == 3'(JOBS - 1)) begin
               state_in = ST_WALK_CHK;
               job_in   = '0;
            end else begin
               state_in = ST_DIV_INIT;
               job_in   = job_ff + 1'b1;
            end
         end
         ST_WALK_CHK: begin
            if (stat.walk_go) begin
               cmd.op   = OP_WALK_READ;
               state_in = ST_WALK_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WALK_READ: begin
            cmd.op   = OP_WALK_EVAL;
            state_in = stat.cell_hit ? ST_DONE : ST_WALK_CHK;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !cmd.req_ready)
      else $error("request taken outside idle");
   a_sqrt_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && cnt_ff == CNT_W'(ITER - 1)) |=> state_ff == ST_DIV_INIT)
      else $error("root iteration count broken");
   a_read_after_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK_READ |-> $past(state_ff) == ST_WALK_CHK)
      else $error("cell evaluated without a read");
`endif

endmodule
`default_nettype wire

/* rtl/core/vrt_dpath.sv */
// Datapath: block store, root and divider iterations, DDA walk, response register.
`default_nettype none
module vrt_dpath import vrt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output stat_type     stat,
   vrt_req_if.sink      req_chan,
   vrt_rsp_if.source    rsp_chan
);

   function automatic logic in_grid(input logic signed [CELL_W-1:0] x,
                                    input logic signed [CELL_W-1:0] y,
                                    input logic signed [CELL_W-1:0] z);
      in_grid = (x >= 0) && (x < GRID_X) && (y >= 0) && (y < GRID_Y) &&
                (z >= 0) && (z < GRID_Z);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CELL_W-1:0] x,
                                                   input logic signed [CELL_W-1:0] y,
                                                   input logic signed [CELL_W-1:0] z);
      int xi, yi, zi;
      xi = int'(x);
      yi = int'(y);
      zi = int'(z);
      cell_addr = ADDR_W'((xi * GRID_Y + yi) * GRID_Z + zi);
   endfunction

   logic signed [15:0]       org_ff [3];
   logic [15:0]              mag_ff [3];
   logic                     neg_ff [3];
   logic [23:0]              limit_ff;
   logic [31:0]              sum_ff;
   logic [63:0]              rad_ff;
   logic [33:0]              srem_ff;
   logic [31:0]              root_ff;
   logic [31:0]              quo_ff;
   logic [16:0]              drem_ff;
   logic [15:0]              dsor_ff;
   logic [TIME_W-1:0]        nbt_ff [3];
   logic [TIME_W-1:0]        cct_ff [3];
   logic [TIME_W-1:0]        trav_ff;
   logic signed [CELL_W-1:0] cell_ff [3];
   logic [1:0]               nrm_ff [3];
   logic [STEP_W-1:0]        steps_ff;
   logic                     hit_ff;
   logic                     ingrid_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [7:0]               rsp_cell_ff [3];
   logic [1:0]               rsp_nrm_ff [3];

   logic signed [15:0]       req_org [3];
   logic signed [15:0]       req_dir [3];
   logic signed [CELL_W-1:0] blk [3];
   logic                     blk_in_grid;
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [7:0]               ram_wr_data;
   logic                     ram_rd_en;
   logic [7:0]               ram_rd_data;
   logic                     cur_in_grid;
   logic [ADDR_W-1:0]        cur_addr;
   logic [1:0]               ax;
   logic [1:0]               sel;
   logic [33:0]              sq_r;
   logic [33:0]              sq_trial;
   logic [16:0]              dv_r;
   logic [8:0]               e_val;
   logic [40:0]              e_prod;
   logic [TIME_W:0]          nbt_sum;
   logic                     rsp_take;

   assign req_org[0] = req_chan.origin_x;
   assign req_org[1] = req_chan.origin_y;
   assign req_org[2] = req_chan.origin_z;
   assign req_dir[0] = req_chan.dir_x;
   assign req_dir[1] = req_chan.dir_y;
   assign req_dir[2] = req_chan.dir_z;
   assign blk[0] = CELL_W'(req_chan.block_x);
   assign blk[1] = CELL_W'(req_chan.block_y);
   assign blk[2] = CELL_W'(req_chan.block_z);
   assign blk_in_grid = in_grid(blk[0], blk[1], blk[2]);
   assign req_chan.ready = cmd.req_ready;

   assign cur_in_grid = in_grid(cell_ff[0], cell_ff[1], cell_ff[2]);
   assign cur_addr    = cell_addr(cell_ff[0], cell_ff[1], cell_ff[2]);

   // block store: clearing sweep and writes on one port, walk reads on the other
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cmd.addr;
      ram_wr_data = '0;
      if (cmd.op == OP_CLEAR_WR) begin
         ram_wr_en = 1'b1;
      end else if (cmd.op == OP_BLOCK_WR) begin
         ram_wr_en   = blk_in_grid;
         ram_wr_addr = cell_addr(blk[0], blk[1], blk[2]);
         ram_wr_data = req_chan.block_type;
      end
   end
   assign ram_rd_en = (cmd.op == OP_WALK_READ);

   vrt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_addr),
      .rd_data (ram_rd_data)
   );

   // jobs 0..2 give crossing times, 3..5 first boundary times, axis = job mod 3
   assign ax = (cmd.idx < 3'd3) ? cmd.idx[1:0] : 2'(cmd.idx - 3'd3);
   assign e_val  = neg_ff[ax] ? {1'b0, org_ff[ax][7:0]} : 9'd256 - {1'b0, org_ff[ax][7:0]};
   assign e_prod = 41'(e_val) * 41'(root_ff);

   assign sq_r     = {srem_ff[31:0], rad_ff[63:62]};
   assign sq_trial = {root_ff, 2'b01};
   assign dv_r     = {drem_ff[15:0], quo_ff[31]};

   // strictly smaller x wins, then strictly smaller y, else z
   always_comb begin
      if (nbt_ff[0] < nbt_ff[1] && nbt_ff[0] < nbt_ff[2]) begin
         sel = 2'd0;
      end else if (nbt_ff[1] < nbt_ff[2]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
   end
   assign nbt_sum = {1'b0, nbt_ff[sel]} + {1'b0, cct_ff[sel]};

   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;
   assign stat.near_zero = (sum_ff <= SUM_MIN);
   assign stat.walk_go   = (trav_ff < {8'b0, limit_ff}) && (steps_ff < STEP_W'(MAX_STEPS));
   assign stat.cell_hit  = ingrid_ff && (ram_rd_data != 8'd0);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         steps_ff     <= '0;
      end else begin
         if (cmd.op == OP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == OP_RAY_LOAD) begin
            hit_ff   <= 1'b0;
            steps_ff <= '0;
         end else if (cmd.op == OP_WALK_READ) begin
            steps_ff <= steps_ff + 1'b1;
         end else if (cmd.op == OP_WALK_EVAL && stat.cell_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_RAY_LOAD: begin
            for (int a = 0; a < 3; a++) begin
               org_ff[a] <= req_org[a];
               neg_ff[a] <= req_dir[a][15];
               mag_ff[a] <= req_dir[a][15] ? 16'(-req_dir[a]) : 16'(req_dir[a]);
               nrm_ff[a] <= '0;
            end
            limit_ff <= {req_chan.max_distance, 8'b0};
            sum_ff   <= '0;
            trav_ff  <= '0;
         end
         OP_SUMSQ: begin
            sum_ff <= sum_ff + 32'(mag_ff[cmd.idx[1:0]]) * 32'(mag_ff[cmd.idx[1:0]]);
         end
         OP_SQRT_INIT: begin
            rad_ff  <= {sum_ff, 32'b0};
            srem_ff <= '0;
            root_ff <= '0;
            for (int a = 0; a < 3; a++) begin
               cell_ff[a] <= CELL_W'(org_ff[a] >>> 8);
            end
         end
         OP_SQRT_STEP: begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (sq_r >= sq_trial) begin
               srem_ff <= sq_r - sq_trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= sq_r;
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         OP_DIV_INIT: begin
            // boundary: floor(e*L/256) then / |d| equals floor(e*L / (256*|d|))
            quo_ff  <= (cmd.idx < 3'd3) ? root_ff : e_prod[39:8];
            dsor_ff <= mag_ff[ax];
            drem_ff <= '0;
         end
         OP_DIV_STEP: begin
            // a zero divisor yields all ones, the infinite time
            if (dv_r >= {1'b0, dsor_ff}) begin
               drem_ff <= dv_r - {1'b0, dsor_ff};
               quo_ff  <= {quo_ff[30:0], 1'b1};
            end else begin
               drem_ff <= dv_r;
               quo_ff  <= {quo_ff[30:0], 1'b0};
            end
         end
         OP_DIV_STORE: begin
            if (cmd.idx < 3'd3) begin
               cct_ff[ax] <= quo_ff;
            end else begin
               nbt_ff[ax] <= quo_ff;
            end
         end
         OP_WALK_READ: begin
            ingrid_ff <= cur_in_grid;
         end
         OP_WALK_EVAL: begin
            if (!stat.cell_hit) begin
               trav_ff     <= nbt_ff[sel];
               nbt_ff[sel] <= nbt_sum[TIME_W] ? T_INF : nbt_sum[TIME_W-1:0];
               cell_ff[sel] <= neg_ff[sel] ? cell_ff[sel] - 1'b1 : cell_ff[sel] + 1'b1;
               for (int a = 0; a < 3; a++) begin
                  if (2'(a) == sel) begin
                     nrm_ff[a] <= neg_ff[a] ? 2'b01 : 2'b11;
                  end else begin
                     nrm_ff[a] <= 2'b00;
                  end
               end
            end
         end
         OP_RESULT: begin
            rsp_hit_ff <= hit_ff;
            for (int a = 0; a < 3; a++) begin
               rsp_cell_ff[a] <= hit_ff ? cell_ff[a][7:0] : 8'd0;
               rsp_nrm_ff[a]  <= hit_ff ? nrm_ff[a] : 2'b00;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.hit_x    = rsp_cell_ff[0];
   assign rsp_chan.hit_y    = rsp_cell_ff[1];
   assign rsp_chan.hit_z    = rsp_cell_ff[2];
   assign rsp_chan.normal_x = rsp_nrm_ff[0];
   assign rsp_chan.normal_y = rsp_nrm_ff[1];
   assign rsp_chan.normal_z = rsp_nrm_ff[2];

`ifndef SYNTHESIS
   a_hit_needs_read: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> steps_ff != '0)
      else $error("hit without any cell read");
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESULT |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response register overwritten");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_hit_ff)))
      else $error("waiting result dropped or changed");
`endif

endmodule
`default_nettype wire

/* rtl/core/voxel_ray_traversal_unit.sv */
// Top level of the voxel ray traversal unit.
//
//   channel    direction  carries
//   req_chan   in         block write (kind 0) or ray cast (kind 1)
//   rsp_chan   out        hit flag, hit cell, entry face normal; one per ray
//
// After reset the block store is swept to air, one cell a cycle, over all
// GRID_X*GRID_Y*GRID_Z cells (262144 at 64^3); no item is taken meanwhile. A write
// item is stored as it is taken. A ray item is accepted, then set up: the sum of
// squares, the bit-serial root and six 32-bit quotients on one divider. Each visited
// cell then takes a check and one store read, one more check ends a walk without a
// hit, and the response register is loaded; a full response register stalls it.
`default_nettype none
module voxel_ray_traversal_unit import vrt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   vrt_req_if.sink   req_chan,
   vrt_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .stat      (stat),
      .cmd       (cmd)
   );

   vrt_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
